>>> rtl/core/i2c_master_byte_engine_core_macros.svh
// Assertion macros shared by the I2C master byte engine RTL.
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define I2CM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition on one edge implies another on the next edge.
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define I2CM_ASSERT(label, prop, msg)
`define I2CM_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/core/i2cm_pkg.sv
// Types and constants for the I2C master byte engine.
`timescale 1ns / 1ps

package i2cm_pkg;

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd255;
  localparam int unsigned BYTE_BITS = 8;
  localparam logic [2:0] LAST_BIT = 3'(BYTE_BITS - 1);

  // One tick: optional command plus the sampled SDA level
  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] command;
    logic [7:0] tx_byte;
    logic       read_nack;
    logic       sda_in;
  } in_item_t;

  // Line levels and status after one tick
  typedef struct packed {
    logic       scl_drive;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       no_ack;
  } out_item_t;

endpackage

>>> rtl/core/i2cm_in_stage.sv
// Input register stage: captures one tick beat and hands it to the engine.
`timescale 1ns / 1ps

module i2cm_in_stage
  import i2cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  input  logic     adv,
  output logic     stage_valid,
  output in_item_t stage_item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     take;

  // Stall only while holding a beat that cannot move on
  assign in_stall = valid_r & ~adv;
  assign take     = in_valid & ~in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign stage_valid = valid_r;
  assign stage_item  = item_r;

endmodule

>>> rtl/core/i2cm_engine.sv
// Bit-step sequencer: one line step per tick, holds phase and byte state.
`timescale 1ns / 1ps

module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  in_item_t   item,
  input  logic [7:0] ack_poll_limit,
  output out_item_t  result
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST1, PH_ST2, PH_ST3, PH_ST4,
    PH_SP1, PH_SP2, PH_SP3, PH_SP4,
    PH_WR_SET, PH_WR_HIGH, PH_WR_LOW,
    PH_WA_REL, PH_WA_HIGH, PH_WA_POLL,
    PH_RD_REL, PH_RD_HIGH, PH_RD_LOW,
    PH_RA_SET, PH_RA_HIGH, PH_RA_LOW
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [2:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [7:0] poll_cnt_r, poll_cnt_nxt;
  logic       nack_r, nack_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       ack_fail_r, ack_fail_nxt;
  logic [7:0] rx_hold_r, rx_hold_nxt;
  logic       done;
  logic       poll_last;

  // Limit of zero behaves as one: the first sample already reaches it
  assign poll_last = ({1'b0, poll_cnt_r} + 9'd1) >= {1'b0, ack_poll_limit};

  always_comb begin
    phase_t ph;
    ph           = phase_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    poll_cnt_nxt = poll_cnt_r;
    nack_nxt     = nack_r;
    scl_nxt      = scl_r;
    sda_nxt      = sda_r;
    ack_fail_nxt = ack_fail_r;
    rx_hold_nxt  = rx_hold_r;
    done         = 1'b0;

    // Launch a command only from idle; it takes its first step this tick
    if (phase_r == PH_IDLE && item.cmd_valid) begin
      unique case (cmd_t'(item.command))
        CMD_START: ph = PH_ST1;
        CMD_STOP:  ph = PH_SP1;
        CMD_WRITE: begin
          shift_nxt   = item.tx_byte;
          bit_cnt_nxt = '0;
          ph          = PH_WR_SET;
        end
        CMD_READ: begin
          nack_nxt  = item.read_nack;
          shift_nxt = '0;
          ph        = PH_RD_REL;
        end
        default: ph = PH_IDLE;
      endcase
    end

    phase_nxt = ph;
    unique case (ph)
      PH_ST1: begin sda_nxt = 1'b1; phase_nxt = PH_ST2; end
      PH_ST2: begin scl_nxt = 1'b1; phase_nxt = PH_ST3; end
      PH_ST3: begin sda_nxt = 1'b0; phase_nxt = PH_ST4; end
      PH_ST4: begin scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1; end
      PH_SP1: begin scl_nxt = 1'b0; phase_nxt = PH_SP2; end
      PH_SP2: begin sda_nxt = 1'b0; phase_nxt = PH_SP3; end
      PH_SP3: begin scl_nxt = 1'b1; phase_nxt = PH_SP4; end
      PH_SP4: begin sda_nxt = 1'b1; phase_nxt = PH_IDLE; done = 1'b1; end
      PH_WR_SET: begin
        scl_nxt   = 1'b0;
        sda_nxt   = shift_nxt[7];
        phase_nxt = PH_WR_HIGH;
      end
      PH_WR_HIGH: begin scl_nxt = 1'b1; phase_nxt = PH_WR_LOW; end
      PH_WR_LOW: begin
        scl_nxt   = 1'b0;
        shift_nxt = {shift_r[6:0], 1'b0};
        if (bit_cnt_r == LAST_BIT) begin
          bit_cnt_nxt = '0;
          phase_nxt   = PH_WA_REL;
        end else begin
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          phase_nxt   = PH_WR_SET;
        end
      end
      PH_WA_REL: begin sda_nxt = 1'b1; phase_nxt = PH_WA_HIGH; end
      PH_WA_HIGH: begin
        scl_nxt      = 1'b1;
        poll_cnt_nxt = '0;
        phase_nxt    = PH_WA_POLL;
      end
      // Poll the acknowledge; every sample counts, the last one included
      PH_WA_POLL: begin
        if (!item.sda_in) begin
          ack_fail_nxt = 1'b0;
          scl_nxt      = 1'b0;
          phase_nxt    = PH_IDLE;
          done         = 1'b1;
        end else if (poll_last) begin
          ack_fail_nxt = 1'b1;
          scl_nxt      = 1'b0;
          phase_nxt    = PH_IDLE;
          done         = 1'b1;
        end else begin
          poll_cnt_nxt = poll_cnt_r + 8'd1;
        end
      end
      PH_RD_REL: begin
        scl_nxt     = 1'b0;
        sda_nxt     = 1'b1;
        bit_cnt_nxt = '0;
        phase_nxt   = PH_RD_HIGH;
      end
      PH_RD_HIGH: begin scl_nxt = 1'b1; phase_nxt = PH_RD_LOW; end
      PH_RD_LOW: begin
        shift_nxt = {shift_r[6:0], item.sda_in};
        scl_nxt   = 1'b0;
        if (bit_cnt_r == LAST_BIT) begin
          bit_cnt_nxt = '0;
          rx_hold_nxt = {shift_r[6:0], item.sda_in};
          phase_nxt   = PH_RA_SET;
        end else begin
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          phase_nxt   = PH_RD_HIGH;
        end
      end
      PH_RA_SET:  begin sda_nxt = nack_r; phase_nxt = PH_RA_HIGH; end
      PH_RA_HIGH: begin scl_nxt = 1'b1; phase_nxt = PH_RA_LOW; end
      PH_RA_LOW:  begin scl_nxt = 1'b0; phase_nxt = PH_IDLE; done = 1'b1; end
      default:    phase_nxt = PH_IDLE;
    endcase
  end

  // Hold state; advance one step per accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      poll_cnt_r <= '0;
      nack_r     <= 1'b0;
      scl_r      <= 1'b1;
      sda_r      <= 1'b1;
      ack_fail_r <= 1'b0;
      rx_hold_r  <= '0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      poll_cnt_r <= poll_cnt_nxt;
      nack_r     <= nack_nxt;
      scl_r      <= scl_nxt;
      sda_r      <= sda_nxt;
      ack_fail_r <= ack_fail_nxt;
      rx_hold_r  <= rx_hold_nxt;
    end
  end

  // Result of this step, registered by the caller
  always_comb begin
    result.scl_drive = scl_nxt;
    result.sda_drive = sda_nxt;
    result.busy_res  = (phase_nxt != PH_IDLE);
    result.done_res  = done;
    result.rx_byte   = rx_hold_nxt;
    result.no_ack    = ack_fail_nxt;
  end

endmodule

>>> rtl/core/i2c_master_byte_engine_core.sv
// Top level of the I2C master byte engine: input stage, sequencer, result register.
//
// Usage: drive one beat on the in_ channel per bit-time tick from a
// prescaler. A beat carries an optional command (start, stop, write byte,
// read byte) and the sampled SDA level. Commands are taken only while the
// engine is idle; on busy ticks the command fields are ignored.
// Each accepted beat yields exactly one out_ beat with the SCL/SDA drive
// levels, busy, done, the last received byte and the no-ack flag.
// The input register captures an accepted beat; its result enters the
// result register when the beat advances, held back while out_stall keeps
// that register full. Throughput: one beat per cycle while out_ is not
// stalled, set by the single-step sequencer between the two registers.
// If out_stall is held, one result waits in the result register and one
// more beat is taken into the input register; then in_stall rises.
// cfg_wr_en/cfg_wr_data set the ACK poll limit; write it only while idle.
// Reset (rst_n low, synchronous) empties both stages, returns to idle,
// releases both lines and sets the poll limit to 255.
`timescale 1ns / 1ps
`include "i2c_master_byte_engine_core_macros.svh"

module i2c_master_byte_engine_core
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  logic [7:0] ack_poll_limit_r;
  logic       stage_valid;
  in_item_t   stage_item;
  logic       adv;
  out_item_t  step_result;
  logic       out_valid_r;
  out_item_t  out_item_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_poll_limit_r <= ACK_POLL_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      ack_poll_limit_r <= cfg_wr_data;
    end
  end

  // Move a beat on when the result register is empty or draining
  assign adv = stage_valid & (~out_valid_r | ~out_stall);

  i2cm_in_stage u_in_stage (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .adv         (adv),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  i2cm_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_en        (adv),
    .item           (stage_item),
    .ack_poll_limit (ack_poll_limit_r),
    .result         (step_result)
  );

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `I2CM_ASSERT(a_stall_needs_full_out, !in_stall || out_valid_r, "input stalled with empty result register")
  `I2CM_ASSERT_NEXT(a_no_drop, out_valid_r && out_stall, out_valid_r, "stalled result dropped")
  `I2CM_ASSERT(a_done_not_busy, !(out_valid_r && out_item_r.done_res && out_item_r.busy_res), "done and busy together")
  `I2CM_ASSERT_NEXT(a_stall_holds_stage, in_stall, stage_valid, "stalled input stage lost its beat")

endmodule
